// ----- rtl/core/mu8d_pkg.sv -----
package mu8d_pkg;

   // field widths
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned LenWidth   = 3;
   localparam int unsigned DataWidth  = 24;

   // sequence lengths, zero means no sequence open
   localparam logic [LenWidth-1:0] LenNone      = 3'd0;
   localparam logic [LenWidth-1:0] LenTwo       = 3'd2;
   localparam logic [LenWidth-1:0] LenThree     = 3'd3;
   localparam logic [LenWidth-1:0] LenSurrogate = 3'd6;

   // byte positions inside an open sequence
   localparam logic [LenWidth-1:0] PosFirst  = 3'd1;
   localparam logic [LenWidth-1:0] PosSecond = 3'd2;
   localparam logic [LenWidth-1:0] PosFourth = 3'd4;
   localparam logic [LenWidth-1:0] PosFifth  = 3'd5;

   // special byte values
   localparam logic [ByteWidth-1:0] SurrogateLead = 8'hED;
   localparam logic [CpWidth-1:0]   SupplBase     = 21'h010000;

   // decoder state between words
   typedef struct packed {
      logic [LenWidth-1:0] seq_len;
      logic [LenWidth-1:0] seen;
      logic [CpWidth-1:0]  partial;
   } dec_state_type;

   // one decoded result
   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      logic               truncated;
      logic               last;
   } dec_result_type;

endpackage

// ----- rtl/core/mu8d_step.sv -----
module mu8d_step
   import mu8d_pkg::*;
(
   input  dec_state_type        state_cur,
   input  logic [ByteWidth-1:0] data_byte,
   input  logic                 end_of_string,
   output dec_state_type        state_nxt,
   output dec_result_type       result
);

   dec_state_type upd;
   logic          done;

   // lead byte picks the length, continuation bytes fold into the value
   always_comb begin
      upd = state_cur;
      if (state_cur.seq_len == LenNone) begin
         upd.seen = PosFirst;
         if (!data_byte[5]) begin
            upd.seq_len = LenTwo;
            upd.partial = {10'd0, data_byte[4:0], 6'd0};
         end else if (data_byte == SurrogateLead) begin
            upd.seq_len = LenSurrogate;
            upd.partial = SupplBase;
         end else begin
            upd.seq_len = LenThree;
            upd.partial = {5'd0, data_byte[3:0], 12'd0};
         end
      end else begin
         upd.seen = state_cur.seen + 3'd1;
         if (state_cur.seq_len == LenSurrogate) begin
            unique case (state_cur.seen)
               PosFirst:  upd.partial = state_cur.partial + {1'b0, data_byte[3:0], 16'd0};
               PosSecond: upd.partial = state_cur.partial | {5'd0, data_byte[5:0], 10'd0};
               PosFourth: upd.partial = state_cur.partial | {11'd0, data_byte[3:0], 6'd0};
               PosFifth:  upd.partial = state_cur.partial | {15'd0, data_byte[5:0]};
               default:   upd.partial = state_cur.partial;
            endcase
         end else if (state_cur.seq_len == LenThree && state_cur.seen == PosFirst) begin
            upd.partial = state_cur.partial | {9'd0, data_byte[5:0], 6'd0};
         end else begin
            upd.partial = state_cur.partial | {15'd0, data_byte[5:0]};
         end
      end
   end

   assign done = upd.seen >= upd.seq_len;

   // single byte, completed sequence, cut-off sequence or nothing
   always_comb begin
      state_nxt         = '0;
      result.emit       = 1'b1;
      result.code_point = '0;
      result.truncated  = 1'b0;
      result.last       = end_of_string;
      if (state_cur.seq_len == LenNone && !data_byte[7]) begin
         result.code_point = {13'd0, data_byte};
      end else if (done) begin
         result.code_point = upd.partial;
      end else if (end_of_string) begin
         result.truncated = 1'b1;
      end else begin
         result.emit = 1'b0;
         state_nxt   = upd;
      end
   end

endmodule

// ----- rtl/core/modified_utf8_decoder_unit.sv -----
// decoder for the modified utf-8 strings of class files, one byte per word
// req channel: req_tdata carries one encoded byte, req_tlast marks the last
// byte of a string. rsp channel: rsp_tdata carries the code point, rsp_tuser
// flags a string that ended inside a multi-byte sequence (code point zero),
// rsp_tlast marks the result caused by the last byte of the string.
// a lead byte below 0x80 is a whole character, other leads open a sequence
// of two, three or six (surrogate pair) bytes; a code point leaves once its
// final byte is in. bytes that neither finish a sequence nor end a string
// give no result.
// the result of an accepted byte is registered in the single result register,
// which holds each code point until the receiver takes it; one byte is taken
// every cycle unless a result waits on a stalled receiver.
// while rsp_tready is low and a result waits, req_tready drops; a new byte
// is taken in the same cycle that the waiting result leaves.
// reset clears the open sequence and the result valid flag; no byte is
// taken while reset is high.
module modified_utf8_decoder_unit
   import mu8d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ByteWidth-1:0] req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic                 rsp_tuser,   // [0] truncated
   output logic                 rsp_tlast
);

   dec_state_type  state_ff, state_in;
   dec_result_type result;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CpWidth-1:0] cp_ff, cp_in;
   logic           trunc_ff, trunc_in;
   logic           last_ff, last_in;
   logic           accept;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   mu8d_step u_step (
      .state_cur     (state_ff),
      .data_byte     (req_tdata),
      .end_of_string (req_tlast),
      .state_nxt     (state_in),
      .result        (result)
   );

   // result register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cp_in        = cp_ff;
      trunc_in     = trunc_ff;
      last_in      = last_ff;
      if (accept && result.emit) begin
         rsp_valid_in = 1'b1;
         cp_in        = result.code_point;
         trunc_in     = result.truncated;
         last_in      = result.last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cp_ff    <= cp_in;
      trunc_ff <= trunc_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, cp_ff};
   assign rsp_tuser  = trunc_ff;
   assign rsp_tlast  = last_ff;

   // a cut-off string gives a zero code point and ends the string
   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && trunc_ff |-> cp_ff == '0 && last_ff)
      else $error("truncated result with nonzero code point or no last");

   // the last byte of a string always leaves no sequence open
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> state_ff.seq_len == LenNone)
      else $error("sequence still open after end of string");

   // the last byte of a string always yields a result
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> rsp_valid_ff && last_ff)
      else $error("end of string without a result");

   // an open sequence has seen fewer bytes than its length
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.seq_len != LenNone |-> state_ff.seen != '0 && state_ff.seen < state_ff.seq_len)
      else $error("byte count out of range");

   // no sequence open means no bytes counted
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.seq_len == LenNone |-> state_ff.seen == '0)
      else $error("byte count without open sequence");

endmodule

// ----- tb/sv/tb_modified_utf8_decoder_unit.sv -----
module tb_modified_utf8_decoder_unit
   import mu8d_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteWidth-1:0] req_tdata = '0;   // [7:0] data_byte
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DataWidth-1:0] rsp_tdata;        // [20:0] code_point, [23:21] zero
   logic                 rsp_tuser;        // [0] truncated
   logic                 rsp_tlast;

   // decoder state mirrored by the testbench
   logic [LenWidth-1:0] open_len = LenNone;
   logic [LenWidth-1:0] got_count = '0;
   logic [CpWidth-1:0]  acc_value = '0;

   dec_result_type pending_code_points[$];

   bit          no_idle = 1'b0;
   int unsigned error_count = 0;
   int unsigned bytes_accepted = 0;
   int unsigned code_points_seen = 0;
   int unsigned truncations_seen = 0;
   int unsigned surrogates_seen = 0;

   modified_utf8_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic queue_code_point(input logic [CpWidth-1:0] cp, input logic trunc,
                                   input logic last);
      dec_result_type res;
      res.emit       = 1'b1;
      res.code_point = cp;
      res.truncated  = trunc;
      res.last       = last;
      pending_code_points.push_back(res);
      open_len  = LenNone;
      got_count = '0;
      acc_value = '0;
   endtask

   // expected code point for one accepted byte, if the byte causes one
   task automatic decode_step(input logic [ByteWidth-1:0] b, input logic eos);
      // a plain ascii byte is a whole character
      if (open_len == LenNone && !b[7]) begin
         queue_code_point(CpWidth'(b), 1'b0, eos);
         return;
      end
      if (open_len == LenNone) begin
         got_count = PosFirst;
         if (!b[5]) begin
            open_len  = LenTwo;
            acc_value = CpWidth'(b[4:0]) << 6;
         end else if (b == SurrogateLead) begin
            open_len  = LenSurrogate;
            acc_value = SupplBase;
         end else begin
            open_len  = LenThree;
            acc_value = CpWidth'(b[3:0]) << 12;
         end
      end else begin
         // continuation bytes are masked, never checked
         case (open_len)
            LenSurrogate: begin
               case (got_count)
                  PosFirst:  acc_value += CpWidth'(b[3:0]) << 16;
                  PosSecond: acc_value += CpWidth'(b[5:0]) << 10;
                  PosFourth: acc_value += CpWidth'(b[3:0]) << 6;
                  PosFifth:  acc_value += CpWidth'(b[5:0]);
                  default: ;
               endcase
            end
            LenThree: begin
               if (got_count == PosFirst) acc_value |= CpWidth'(b[5:0]) << 6;
               else acc_value |= CpWidth'(b[5:0]);
            end
            default: acc_value |= CpWidth'(b[5:0]);
         endcase
         got_count++;
      end
      if (got_count >= open_len) begin
         if (open_len == LenSurrogate) surrogates_seen++;
         queue_code_point(acc_value, 1'b0, eos);
      end else if (eos) begin
         queue_code_point('0, 1'b1, 1'b1);
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
   end

   // predict on accepted bytes, compare accepted code points
   always @(posedge clock) begin : monitor
      dec_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            decode_step(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            code_points_seen++;
            if (rsp_tuser) truncations_seen++;
            if (pending_code_points.size() == 0) begin
               report_mismatch("code point with nothing pending", rsp_tdata, 0);
            end else begin
               want = pending_code_points.pop_front();
               if (rsp_tdata !== DataWidth'(want.code_point))
                  report_mismatch("code_point", rsp_tdata, want.code_point);
               if (rsp_tuser !== want.truncated)
                  report_mismatch("truncated", rsp_tuser, want.truncated);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_of_string", rsp_tlast, want.last);
            end
         end
      end
   end

   // one byte over the request channel, with random gaps
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic eos);
      while (!no_idle && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_string(input logic [ByteWidth-1:0] seq[$]);
      for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
   endtask

   function automatic logic [ByteWidth-1:0] continuation_byte();
      if ($urandom_range(99) < 90) return {2'b10, 6'($urandom_range(63))};
      return 8'($urandom_range(255));
   endfunction

   // one random character, mostly well formed, sometimes a stray byte
   task automatic append_char(ref logic [ByteWidth-1:0] seq[$]);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         seq.push_back({1'b0, 7'($urandom_range(127))});
      end else if (pick < 50) begin
         seq.push_back({1'b1, 1'($urandom_range(1)), 1'b0, 5'($urandom_range(31))});
         seq.push_back(continuation_byte());
      end else if (pick < 70) begin
         seq.push_back({3'b111, 5'($urandom_range(31))});
         seq.push_back(continuation_byte());
         seq.push_back(continuation_byte());
      end else if (pick < 85) begin
         seq.push_back(SurrogateLead);
         seq.push_back({4'hA, 4'($urandom_range(15))});
         seq.push_back(continuation_byte());
         // the fourth byte adds nothing, so it may be anything
         seq.push_back(($urandom_range(99) < 80) ? SurrogateLead : 8'($urandom_range(255)));
         seq.push_back({4'hB, 4'($urandom_range(15))});
         seq.push_back(continuation_byte());
      end else begin
         seq.push_back(8'($urandom_range(255)));
      end
   endtask

   // random strings until about byte_budget bytes have gone out
   task automatic run_random_strings(input int unsigned byte_budget);
      logic [ByteWidth-1:0] seq[$];
      int unsigned sent, chars, last_start, last_len;
      sent = 0;
      while (sent < byte_budget) begin
         seq = {};
         chars = $urandom_range(12, 1);
         last_start = 0;
         for (int k = 0; k < chars; k++) begin
            last_start = seq.size();
            append_char(seq);
         end
         // sometimes cut the string inside its last sequence
         last_len = seq.size() - last_start;
         if (last_len > 1 && $urandom_range(99) < 20)
            seq = seq[0 : last_start + $urandom_range(last_len - 1, 1) - 1];
         send_string(seq);
         sent += seq.size();
      end
   endtask

   task automatic test_single_bytes();
      send_string('{8'h00});
      send_string('{8'h7F});
   endtask

   task automatic test_two_byte();
      send_string('{8'hC0, 8'h80});
      send_string('{8'hDF, 8'hBF});
   endtask

   task automatic test_three_byte();
      send_string('{8'hE0, 8'h80, 8'h80});
      // continuations with wrong top bits are taken as they are
      send_string('{8'hFF, 8'h7F, 8'hFF});
   endtask

   task automatic test_surrogate_pair();
      send_string('{8'hED, 8'hAF, 8'hBF, 8'hED, 8'hBF, 8'hBF});
      send_string('{8'hED, 8'hA0, 8'h80, 8'h00, 8'hB0, 8'h80});
   endtask

   task automatic test_cut_off();
      send_string('{8'hC3});
      send_string('{8'hE2, 8'h82});
      send_string('{8'hED});
      send_string('{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0});
   endtask

   task automatic test_random_traffic();
      run_random_strings(600);
   endtask

   task automatic test_drain_pause();
      run_random_strings(40);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_code_points.size() != 0) @(posedge clock);
      run_random_strings(40);
   endtask

   task automatic test_back_to_back();
      @(posedge clock);
      no_idle = 1'b1;
      run_random_strings(300);
      no_idle = 1'b0;
   endtask

   // run limit
   initial begin
      #8_000_000;
      $display("timeout at %0t", $time);
      $display("modified_utf8_decoder_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_bytes();
      test_two_byte();
      test_three_byte();
      test_surrogate_pair();
      test_cut_off();
      test_random_traffic();
      test_drain_pause();
      test_back_to_back();
      test_random_traffic();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_code_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_code_points.size() != 0)
         report_mismatch("code points never delivered", 0, pending_code_points.size());
      $display("decoded %0d bytes into %0d code points (%0d surrogate pairs, %0d cut off)",
               bytes_accepted, code_points_seen, surrogates_seen, truncations_seen);
      $display("with random gaps on both channels, a drain pause and a gap-free stretch");
      if (error_count == 0) begin
         $display("modified_utf8_decoder_unit regression: pass");
      end else begin
         $display("modified_utf8_decoder_unit regression: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/mu8d_pkg.sv
rtl/core/mu8d_step.sv
rtl/core/modified_utf8_decoder_unit.sv
tb/sv/tb_modified_utf8_decoder_unit.sv
